// ===== sv/stfl_pkg.sv =====
// Shared constants, codes and types of the sorted time table floor lookup.
`timescale 1ns / 1ps

package stfl_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths.
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 12;
	localparam int TIME_W = 32;
	localparam int VAL_W  = 32;
	localparam int REC_W  = TIME_W + VAL_W;

	// Width that holds entry_count, a slot index and the depth itself.
	localparam int SPAN_W = (CFG_W > ADDR_W + 1) ? CFG_W : ADDR_W + 1;

	// Request kinds.
	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH,
		ST_RESULT
	} state_t;

endpackage

// ===== sv/stfl_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module stfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== sv/sorted_time_table_floor_lookup.sv =====
// Top level: sorted time table with binary-search floor (predecessor) lookup.
`timescale 1ns / 1ps

// The block keeps up to 4096 records (signed 32-bit time, raw 32-bit value
// word) in one synchronous RAM. A write request (tuser = 1) stores one record
// at record_index and gives no result; slots at or beyond
// the table depth are dropped. A query request (tuser = 0) searches the first
// entry_count records, which the user keeps sorted by ascending time, and
// returns the value word of the last record whose time is at or before the
// query time; if none qualifies, record 0's value comes back. With
// entry_count zero the result is zero with table_empty set. Requests are
// taken one at a time. A query is accepted with its first RAM probe, then
// searches with one RAM probe per cycle (ceil(log2(n+1)) probes for n
// records, at most 13 for a full table), reads the chosen record's value
// word and hands it to the output register; the single RAM read port, with
// its registered read data, paces the probes. The result sits in an output
// register, so a query's search does not wait for the previous result to be
// taken until it has its own value ready. The user writes entry_count
// through the cfg port only while the block is idle; the block itself does
// not enforce this. The table memory is not cleared by reset.

module sorted_time_table_floor_lookup (
	input  logic                      clk,
	input  logic                      arst_n,

	// Configuration: entry_count.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [stfl_pkg::CFG_W-1:0] cfg_data,

	// Request stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [11:0] record_index, [43:12] key_time, [75:44] record_value, [79:76] zero
	input  logic [79:0]               s_tdata,
	// [0] command
	input  logic                      s_tuser,

	// Result stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [31:0] found_value
	output logic [31:0]               m_tdata,
	// [0] table_empty
	output logic                      m_tuser
);

	localparam int AW = stfl_pkg::ADDR_W;
	localparam int SW = stfl_pkg::SPAN_W;
	localparam int TW = stfl_pkg::TIME_W;
	localparam int VW = stfl_pkg::VAL_W;

	// Request fields.
	logic [stfl_pkg::IDX_W-1:0] in_index;
	logic [TW-1:0]              in_time;
	logic [VW-1:0]              in_value;

	assign in_index = s_tdata[11:0];
	assign in_time  = s_tdata[43:12];
	assign in_value = s_tdata[75:44];

	// Registers.
	stfl_pkg::state_t state_q, state_n;
	logic [SW-1:0]    entry_count_q;
	logic [TW-1:0]    key_q, key_n;
	logic [AW-1:0]    lo_q, lo_n;
	logic [AW-1:0]    hi_q, hi_n;
	logic [AW-1:0]    mid_q, mid_n;
	logic [AW-1:0]    ans_q, ans_n;
	logic [VW-1:0]    res_val_q, res_val_n;
	logic             res_empty_q, res_empty_n;
	logic             out_valid_q, out_valid_n;
	logic [VW-1:0]    out_val_q, out_val_n;
	logic             out_empty_q, out_empty_n;

	// RAM port.
	logic                       ram_en;
	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [stfl_pkg::REC_W-1:0] ram_wdata;
	logic [stfl_pkg::REC_W-1:0] ram_rdata;

	// Search helpers.
	logic [SW-1:0] count_sat;
	logic [AW-1:0] hi_init;
	logic          time_le;
	logic          done;
	logic [AW:0]   mid_sum;

	stfl_ram #(
		.WIDTH(stfl_pkg::REC_W),
		.DEPTH(stfl_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == stfl_pkg::ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_val_q;
	assign m_tuser   = out_empty_q;

	// Record layout in RAM: time low, value high.
	assign ram_wdata = {in_value, in_time};

	// Count clipped to the table depth; last valid slot as the first upper bound.
	assign count_sat = (entry_count_q > SW'(stfl_pkg::TABLE_DEPTH)) ?
		SW'(stfl_pkg::TABLE_DEPTH) : entry_count_q;
	assign hi_init   = AW'(count_sat - SW'(1));

	// Probed record time against the query, signed.
	assign time_le = $signed(ram_rdata[TW-1:0]) <= $signed(key_q);

	always_comb begin
		state_n     = state_q;
		key_n       = key_q;
		lo_n        = lo_q;
		hi_n        = hi_q;
		mid_n       = mid_q;
		ans_n       = ans_q;
		res_val_n   = res_val_q;
		res_empty_n = res_empty_q;
		out_valid_n = out_valid_q & ~m_tready;
		out_val_n   = out_val_q;
		out_empty_n = out_empty_q;
		ram_en      = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = mid_q;
		done        = 1'b0;
		mid_sum     = '0;

		unique case (state_q)
			stfl_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == stfl_pkg::CMD_WRITE) begin
						// Store; out-of-range slots are dropped.
						if (SW'(in_index) < SW'(stfl_pkg::TABLE_DEPTH)) begin
							ram_en   = 1'b1;
							ram_we   = 1'b1;
							ram_addr = AW'(in_index);
						end
					end else begin
						key_n = in_time;
						if (count_sat == '0) begin
							res_val_n   = '0;
							res_empty_n = 1'b1;
							state_n     = stfl_pkg::ST_RESULT;
						end else begin
							lo_n        = '0;
							hi_n        = hi_init;
							mid_n       = hi_init >> 1;
							ans_n       = '0;
							res_empty_n = 1'b0;
							ram_en      = 1'b1;
							ram_addr    = mid_n;
							state_n     = stfl_pkg::ST_SEARCH;
						end
					end
				end
			end

			stfl_pkg::ST_SEARCH: begin
				// lo <= mid <= hi always holds, so the end of the search is
				// seen before a bound would cross zero or the depth.
				if (time_le) begin
					ans_n = mid_q;
					if (mid_q == hi_q) begin
						done = 1'b1;
					end else begin
						lo_n = mid_q + AW'(1);
					end
				end else begin
					if (mid_q == lo_q) begin
						done = 1'b1;
					end else begin
						hi_n = mid_q - AW'(1);
					end
				end
				mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
				ram_en  = 1'b1;
				if (done) begin
					ram_addr = ans_n;
					state_n  = stfl_pkg::ST_FETCH;
				end else begin
					mid_n    = mid_sum[AW:1];
					ram_addr = mid_n;
				end
			end

			stfl_pkg::ST_FETCH: begin
				res_val_n = ram_rdata[stfl_pkg::REC_W-1:TW];
				state_n   = stfl_pkg::ST_RESULT;
			end

			stfl_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					out_valid_n = 1'b1;
					out_val_n   = res_val_q;
					out_empty_n = res_empty_q;
					state_n     = stfl_pkg::ST_IDLE;
				end
			end

			default: begin
				state_n = stfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= stfl_pkg::ST_IDLE;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
			if (cfg_valid) begin
				entry_count_q <= SW'(cfg_data);
			end
		end
	end

	// Payload and search registers.
	always_ff @(posedge clk) begin
		key_q       <= key_n;
		lo_q        <= lo_n;
		hi_q        <= hi_n;
		mid_q       <= mid_n;
		ans_q       <= ans_n;
		res_val_q   <= res_val_n;
		res_empty_q <= res_empty_n;
		out_val_q   <= out_val_n;
		out_empty_q <= out_empty_n;
	end

endmodule
